// ===== rtl/wpms_pkg.sv =====
// package for the wearable power mode sequencer
// holds payload structs, mode, event and boot reason codes and fixed battery constants
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package wpms_pkg;

    // mode codes
    localparam logic [2:0] MODE_BOOTING    = 3'd0;
    localparam logic [2:0] MODE_DISPLAY    = 3'd1;
    localparam logic [2:0] MODE_ACTIVE     = 3'd2;
    localparam logic [2:0] MODE_SYNC       = 3'd3;
    localparam logic [2:0] MODE_SLEEP_PEND = 3'd4;
    localparam logic [2:0] MODE_SLEEPING   = 3'd5;
    localparam logic [2:0] MODE_LOW_BAT    = 3'd6;

    // event codes
    localparam logic [3:0] EV_BOOT_DONE     = 4'd0;
    localparam logic [3:0] EV_DISPLAY_READY = 4'd1;
    localparam logic [3:0] EV_WRIST_RAISED  = 4'd2;
    localparam logic [3:0] EV_WRIST_LOWERED = 4'd3;
    localparam logic [3:0] EV_RADIO_CONN    = 4'd4;
    localparam logic [3:0] EV_TIME_SYNCED   = 4'd5;
    localparam logic [3:0] EV_RADIO_LOST    = 4'd6;
    localparam logic [3:0] EV_TICK          = 4'd7;
    localparam logic [3:0] EV_LOW_BATTERY   = 4'd8;
    localparam logic [3:0] EV_BATTERY_OK    = 4'd9;
    localparam logic [3:0] EV_SYNC_REQ      = 4'd10;
    localparam logic [3:0] EV_COUNT         = 4'd11;

    // boot reason codes
    localparam logic [1:0] REASON_COLD  = 2'd0;
    localparam logic [1:0] REASON_WRIST = 2'd1;
    localparam logic [1:0] REASON_RTC   = 2'd2;

    // battery constants
    localparam logic [6:0] FULL_BATTERY      = 7'd100;
    localparam logic [6:0] CRIT_BATTERY_RST  = 7'd5;

    typedef struct packed {
        logic [3:0] req_type;
        logic [1:0] wake_cause;
        logic [6:0] battery_now;
    } t_in;

    typedef struct packed {
        logic [2:0] mode_now;
        logic       show_time;
        logic       show_sync_screen;
        logic       radio_start;
        logic       radio_stop;
        logic       save_time;
        logic       sleep_now;
        logic       show_low_battery;
        logic       advance_minute;
        logic [6:0] shown_battery;
        logic       ignored;
    } t_out;

endpackage

`default_nettype wire

// ===== rtl/wearable_power_mode_sequencer.sv =====
// Power mode sequencer for a wearable: accepts one event transfer per cycle while
// the output side is not stalled, over a two-deep item path of input register,
// transition logic and result register. Throughput is one item per clock unless the
// output stalls; an accepted item waits in the input register and is evaluated into
// the result register when the output side is free. The mode, latched boot reason,
// pending-sync flag and held battery level are updated at the same edge as the
// result register, so back-to-back items see each other's effects in order.
// The critical battery threshold is written through i_cfg_we / i_cfg_wdata; the user
// must write it only while no item is in flight (unchecked); it resets to 5 percent.
// depends on wpms_pkg
`timescale 1ns / 1ps
`default_nettype none

module wearable_power_mode_sequencer (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire wpms_pkg::t_in   i_in,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output wpms_pkg::t_out       o_out,
    input  wire logic            i_cfg_we,
    input  wire logic [6:0]      i_cfg_wdata
);

    // input stage
    logic          r_in_valid;
    wpms_pkg::t_in r_in;
    // result stage
    logic           r_out_valid;
    wpms_pkg::t_out r_out;
    wpms_pkg::t_out n_out;
    // sequencer state
    logic [2:0] r_mode, n_mode;
    logic [1:0] r_reason, n_reason;
    logic       r_sync_pend, n_sync_pend;
    logic [6:0] r_battery, n_battery;
    logic [6:0] r_crit;

    logic       w_out_free;
    logic       w_eval;
    logic [6:0] w_sampled;
    logic       w_go;
    logic [2:0] w_target;
    logic       w_acted;

    // handshake between the two stages
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_eval      = r_in_valid && w_out_free;
    assign o_in_ready  = !r_in_valid || w_out_free;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // battery sample saturated to full scale
    assign w_sampled = (r_in.battery_now > wpms_pkg::FULL_BATTERY) ?
                       wpms_pkg::FULL_BATTERY : r_in.battery_now;

    // transition selection
    always_comb begin
        w_go        = 1'b0;
        w_target    = r_mode;
        w_acted     = 1'b1;
        n_reason    = r_reason;
        n_sync_pend = r_sync_pend;
        n_out       = '0;
        if (r_in.req_type >= wpms_pkg::EV_COUNT) begin
            w_acted = 1'b0;
        end else begin
            if (r_in.req_type == wpms_pkg::EV_BOOT_DONE) begin
                n_reason = r_in.wake_cause;
            end
            case (r_mode)
                wpms_pkg::MODE_BOOTING: begin
                    if (r_in.req_type == wpms_pkg::EV_BOOT_DONE) begin
                        w_go     = 1'b1;
                        w_target = (w_sampled <= r_crit) ? wpms_pkg::MODE_LOW_BAT :
                                                           wpms_pkg::MODE_DISPLAY;
                    end else begin
                        w_acted = 1'b0;
                    end
                end
                wpms_pkg::MODE_DISPLAY: begin
                    if (r_in.req_type == wpms_pkg::EV_DISPLAY_READY) begin
                        w_go     = 1'b1;
                        w_target = (r_reason == wpms_pkg::REASON_RTC && !r_sync_pend) ?
                                   wpms_pkg::MODE_SLEEP_PEND : wpms_pkg::MODE_ACTIVE;
                    end else if (r_in.req_type == wpms_pkg::EV_LOW_BATTERY) begin
                        w_go     = 1'b1;
                        w_target = wpms_pkg::MODE_LOW_BAT;
                    end else begin
                        w_acted = 1'b0;
                    end
                end
                wpms_pkg::MODE_ACTIVE: begin
                    if (r_in.req_type == wpms_pkg::EV_WRIST_LOWERED) begin
                        w_go     = 1'b1;
                        w_target = wpms_pkg::MODE_SLEEP_PEND;
                    end else if (r_in.req_type == wpms_pkg::EV_TICK) begin
                        w_go                 = 1'b1;
                        w_target             = wpms_pkg::MODE_DISPLAY;
                        n_out.advance_minute = 1'b1;
                    end else if (r_in.req_type == wpms_pkg::EV_SYNC_REQ ||
                                 r_in.req_type == wpms_pkg::EV_RADIO_CONN) begin
                        w_go        = 1'b1;
                        w_target    = wpms_pkg::MODE_SYNC;
                        n_sync_pend = 1'b1;
                    end else if (r_in.req_type == wpms_pkg::EV_LOW_BATTERY) begin
                        w_go     = 1'b1;
                        w_target = wpms_pkg::MODE_LOW_BAT;
                    end else if (r_in.req_type == wpms_pkg::EV_WRIST_RAISED) begin
                        w_go     = 1'b1;
                        w_target = wpms_pkg::MODE_DISPLAY;
                    end else begin
                        w_acted = 1'b0;
                    end
                end
                wpms_pkg::MODE_SYNC: begin
                    if (r_in.req_type == wpms_pkg::EV_TIME_SYNCED ||
                        r_in.req_type == wpms_pkg::EV_RADIO_LOST) begin
                        w_go             = 1'b1;
                        w_target         = wpms_pkg::MODE_DISPLAY;
                        n_sync_pend      = 1'b0;
                        n_out.radio_stop = 1'b1;
                    end else if (r_in.req_type == wpms_pkg::EV_LOW_BATTERY) begin
                        w_go             = 1'b1;
                        w_target         = wpms_pkg::MODE_LOW_BAT;
                        n_out.radio_stop = 1'b1;
                    end else begin
                        w_acted = 1'b0;
                    end
                end
                wpms_pkg::MODE_SLEEP_PEND: begin
                    if (r_in.req_type == wpms_pkg::EV_DISPLAY_READY) begin
                        w_go     = 1'b1;
                        w_target = wpms_pkg::MODE_SLEEPING;
                    end else if (r_in.req_type == wpms_pkg::EV_WRIST_RAISED) begin
                        w_go     = 1'b1;
                        w_target = wpms_pkg::MODE_DISPLAY;
                        n_reason = wpms_pkg::REASON_WRIST;
                    end else begin
                        w_acted = 1'b0;
                    end
                end
                wpms_pkg::MODE_SLEEPING: begin
                    n_out.sleep_now = 1'b1;
                end
                wpms_pkg::MODE_LOW_BAT: begin
                    if (r_in.req_type == wpms_pkg::EV_DISPLAY_READY) begin
                        w_go     = 1'b1;
                        w_target = wpms_pkg::MODE_SLEEP_PEND;
                    end else if (r_in.req_type == wpms_pkg::EV_BATTERY_OK) begin
                        w_go     = 1'b1;
                        w_target = wpms_pkg::MODE_DISPLAY;
                    end else begin
                        w_acted = 1'b0;
                    end
                end
                default: begin
                    w_acted = 1'b0;
                end
            endcase
        end

        // entry actions of the mode entered
        n_mode    = r_mode;
        n_battery = r_battery;
        if (w_go) begin
            n_mode = w_target;
            case (w_target)
                wpms_pkg::MODE_DISPLAY: begin
                    n_battery       = w_sampled;
                    n_out.show_time = 1'b1;
                end
                wpms_pkg::MODE_SYNC: begin
                    n_out.show_sync_screen = 1'b1;
                    n_out.radio_start      = 1'b1;
                end
                wpms_pkg::MODE_SLEEP_PEND: begin
                    n_out.save_time  = 1'b1;
                    n_out.radio_stop = 1'b1;
                end
                wpms_pkg::MODE_SLEEPING: begin
                    n_out.sleep_now = 1'b1;
                end
                wpms_pkg::MODE_LOW_BAT: begin
                    n_battery              = w_sampled;
                    n_out.show_low_battery = 1'b1;
                end
                default: begin
                end
            endcase
        end

        n_out.mode_now      = n_mode;
        n_out.shown_battery = n_battery;
        n_out.ignored       = !w_acted;
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
        if (w_eval) begin
            r_out <= n_out;
        end
    end

    // sequencer state, updated as each item is evaluated
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= wpms_pkg::MODE_BOOTING;
            r_reason    <= wpms_pkg::REASON_COLD;
            r_sync_pend <= 1'b0;
            r_battery   <= wpms_pkg::FULL_BATTERY;
        end else if (w_eval) begin
            r_mode      <= n_mode;
            r_reason    <= n_reason;
            r_sync_pend <= n_sync_pend;
            r_battery   <= n_battery;
        end
    end

    // critical threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crit <= wpms_pkg::CRIT_BATTERY_RST;
        end else if (i_cfg_we) begin
            r_crit <= i_cfg_wdata;
        end
    end

    // an ignored result carries no strobe
    a_ignored_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.ignored) |->
        !(o_out.show_time || o_out.show_sync_screen || o_out.radio_start ||
          o_out.radio_stop || o_out.save_time || o_out.sleep_now ||
          o_out.show_low_battery || o_out.advance_minute))
        else $error("strobe on ignored result");

    // show_time only on entering display update
    a_show_time_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.show_time) |-> (o_out.mode_now == wpms_pkg::MODE_DISPLAY))
        else $error("show_time outside display update");

    // radio start comes with the sync screen in radio sync
    a_radio_start_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.radio_start) |->
        (o_out.show_sync_screen && o_out.mode_now == wpms_pkg::MODE_SYNC))
        else $error("radio_start without sync entry");

    // mode only moves when an item is evaluated
    a_mode_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_eval) |=> $stable(r_mode))
        else $error("mode changed without a transfer");

endmodule

`default_nettype wire
